@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL, included by ptsc_select.
// The block using them must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PTSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PTSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ptsc_pkg.sv @@
package ptsc_pkg;

    localparam int NS_W    = 31;   // request time fields
    localparam int PQ_W    = 22;   // ns / 1000 quotient
    localparam int PR_W    = 11;   // uncorrected remainder, < 2000
    localparam int CYC_W   = 23;   // timer cycles, 3 * ns / 1000
    localparam int SDUTY_W = 25;   // servo duty below saturation point
    localparam int SR_W    = 10;   // uncorrected servo remainder, < 610
    localparam int CNT_W   = 16;

    // Servo mode
    localparam logic [NS_W-1:0]    SERVO_PERIOD_NS = 31'd20000000;
    localparam logic [NS_W-1:0]    SERVO_SAT_NS    = 31'd19988480;  // 65536 * 305
    localparam logic [SR_W-1:0]    SERVO_NS_CNT    = 10'd305;
    localparam logic [CNT_W-1:0]   COUNT_MAX       = 16'hFFFF;

    // Reciprocals: floor(2^41 / 1000) and floor(2^33 / 305); estimate is q or q-1
    localparam logic [31:0]        RECIP_1000      = 32'd2199023255;
    localparam int                 RECIP_1000_SH   = 41;
    localparam logic [SDUTY_W-1:0] RECIP_305       = 25'd28163719;
    localparam int                 RECIP_305_SH    = 33;
    localparam logic [PR_W-1:0]    NS_PER_GROUP    = 11'd1000;
    localparam logic [PR_W+1:0]    ONE_GROUP       = 13'd1000;
    localparam logic [PR_W+1:0]    TWO_GROUPS      = 13'd2000;

    localparam logic [CYC_W-1:0]   SCALED_LIMIT    = 23'd255;
    localparam int                 NUM_PRESC       = 8;

    // Prescalers 1,2,4,8,16,64,256,1024 as shifts
    localparam logic [3:0] PRESC_SHIFT [NUM_PRESC] =
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10};

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_TOO_LONG  = 2'd2
    } status_t;

    typedef struct packed {
        logic [NS_W-1:0] duty_time_ns;
        logic [NS_W-1:0] period_time_ns;
    } req_t;

    typedef struct packed {
        logic              servo;
        logic              sat;
        logic [NS_W-1:0]   duty;
        logic [NS_W-1:0]   period;
        logic [62:0]       pprod;
        logic [62:0]       dprod;
        logic [49:0]       sprod;
    } s1_t;

    typedef struct packed {
        logic              servo;
        logic              sat;
        logic [PQ_W-1:0]   pq;
        logic [PR_W-1:0]   pr;
        logic [PQ_W-1:0]   dq;
        logic [PR_W-1:0]   dr;
        logic [CNT_W-1:0]  sq;
        logic [SR_W-1:0]   sr;
    } s2_t;

    typedef struct packed {
        logic              servo;
        logic [CYC_W-1:0]  pcyc;
        logic [CYC_W-1:0]  dcyc;
        logic [CNT_W-1:0]  scount;
    } s3_t;

    typedef struct packed {
        logic              servo_mode;
        logic [2:0]        presc_idx;
        logic [7:0]        period_count;
        logic [CNT_W-1:0]  duty_count;
        status_t           status;
    } res_t;

endpackage

@@ hw/rtl/ptsc_mult.sv @@
// Stage 1: reciprocal products and servo decode.
module ptsc_mult (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptsc_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ptsc_pkg::s1_t out_data
);

    logic          valid_reg;
    ptsc_pkg::s1_t data_reg;
    ptsc_pkg::s1_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.servo  = in_data.period_time_ns == ptsc_pkg::SERVO_PERIOD_NS;
        data_next.sat    = in_data.duty_time_ns >= ptsc_pkg::SERVO_SAT_NS;
        data_next.duty   = in_data.duty_time_ns;
        data_next.period = in_data.period_time_ns;
        data_next.pprod  = 63'(in_data.period_time_ns) * 63'(ptsc_pkg::RECIP_1000);
        data_next.dprod  = 63'(in_data.duty_time_ns) * 63'(ptsc_pkg::RECIP_1000);
        data_next.sprod  = 50'(in_data.duty_time_ns[ptsc_pkg::SDUTY_W-1:0])
                           * 50'(ptsc_pkg::RECIP_305);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/ptsc_resid.sv @@
// Stage 2: quotient estimates and their remainders.
module ptsc_resid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptsc_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ptsc_pkg::s2_t out_data
);

    logic          valid_reg;
    ptsc_pkg::s2_t data_reg;
    ptsc_pkg::s2_t data_next;
    logic [ptsc_pkg::PQ_W-1:0]  pq;
    logic [ptsc_pkg::PQ_W-1:0]  dq;
    logic [ptsc_pkg::CNT_W-1:0] sq;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        pq = in_data.pprod[62:ptsc_pkg::RECIP_1000_SH];
        dq = in_data.dprod[62:ptsc_pkg::RECIP_1000_SH];
        // only meaningful below the saturation point, where it fits 16 bits
        sq = in_data.sprod[ptsc_pkg::RECIP_305_SH+ptsc_pkg::CNT_W-1:ptsc_pkg::RECIP_305_SH];
        data_next.servo = in_data.servo;
        data_next.sat   = in_data.sat;
        data_next.pq    = pq;
        data_next.dq    = dq;
        data_next.sq    = sq;
        data_next.pr    = ptsc_pkg::PR_W'(32'(in_data.period)
                          - 32'(pq) * 32'(ptsc_pkg::NS_PER_GROUP));
        data_next.dr    = ptsc_pkg::PR_W'(32'(in_data.duty)
                          - 32'(dq) * 32'(ptsc_pkg::NS_PER_GROUP));
        data_next.sr    = ptsc_pkg::SR_W'(
                          ptsc_pkg::SDUTY_W'(in_data.duty[ptsc_pkg::SDUTY_W-1:0])
                          - ptsc_pkg::SDUTY_W'(sq) * ptsc_pkg::SDUTY_W'(ptsc_pkg::SERVO_NS_CNT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/ptsc_fix.sv @@
// Stage 3: quotient correction, cycles = 3*q + floor(3*r/1000), servo saturation.
module ptsc_fix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ptsc_pkg::s2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ptsc_pkg::s3_t out_data
);

    logic          valid_reg;
    ptsc_pkg::s3_t data_reg;
    ptsc_pkg::s3_t data_next;

    function automatic logic [ptsc_pkg::CYC_W-1:0] to_cycles(
        input logic [ptsc_pkg::PQ_W-1:0] q_est,
        input logic [ptsc_pkg::PR_W-1:0] r_est
    );
        logic [ptsc_pkg::CYC_W-1:0] q;
        logic [ptsc_pkg::PR_W-1:0]  r;
        logic [ptsc_pkg::PR_W+1:0]  r3;
        logic [1:0]                 extra;
        q = ptsc_pkg::CYC_W'(q_est);
        r = r_est;
        if (r >= ptsc_pkg::NS_PER_GROUP)
        begin
            q = q + ptsc_pkg::CYC_W'(1);
            r = r - ptsc_pkg::NS_PER_GROUP;
        end
        r3 = (ptsc_pkg::PR_W+2)'({r, 1'b0}) + (ptsc_pkg::PR_W+2)'(r);
        if (r3 >= ptsc_pkg::TWO_GROUPS)
            extra = 2'd2;
        else if (r3 >= ptsc_pkg::ONE_GROUP)
            extra = 2'd1;
        else
            extra = 2'd0;
        return ptsc_pkg::CYC_W'({q, 1'b0}) + q + ptsc_pkg::CYC_W'(extra);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.servo = in_data.servo;
        data_next.pcyc  = to_cycles(in_data.pq, in_data.pr);
        data_next.dcyc  = to_cycles(in_data.dq, in_data.dr);
        if (in_data.sat)
            data_next.scount = ptsc_pkg::COUNT_MAX;
        else if (in_data.sr >= ptsc_pkg::SERVO_NS_CNT)
            data_next.scount = in_data.sq + ptsc_pkg::CNT_W'(1);
        else
            data_next.scount = in_data.sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/ptsc_select.sv @@
`include "assert_macros.svh"

// Stage 4: prescaler pick, result assembly, output register.
module ptsc_select (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptsc_pkg::s3_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ptsc_pkg::res_t out_data
);

    logic           valid_reg;
    ptsc_pkg::res_t data_reg;
    ptsc_pkg::res_t data_next;
    logic           found;
    logic [2:0]     idx;
    logic [7:0]     sp_sel;
    logic [ptsc_pkg::CYC_W-1:0] sp;
    logic           res_servo;
    logic           res_err;
    logic           res_stall;
    logic           servo_clean;
    logic           err_clean;

    assign in_ready = !valid_reg || out_ready;

    // first prescaler giving a scaled period below 255
    always_comb
    begin
        found  = 1'b0;
        idx    = '0;
        sp_sel = '0;
        for (int i = 0; i < ptsc_pkg::NUM_PRESC; i++)
        begin
            sp = in_data.pcyc >> ptsc_pkg::PRESC_SHIFT[i];
            if (!found && sp < ptsc_pkg::SCALED_LIMIT)
            begin
                found  = 1'b1;
                idx    = 3'(i);
                sp_sel = sp[7:0];
            end
        end
    end

    always_comb
    begin
        data_next.servo_mode      = 1'b0;
        data_next.presc_idx       = '0;
        data_next.period_count    = '0;
        data_next.duty_count      = '0;
        data_next.status          = ptsc_pkg::STATUS_OK;
        priority if (in_data.servo)
        begin
            data_next.servo_mode = 1'b1;
            data_next.duty_count = in_data.scount;
        end
        else if (!found)
            data_next.status = ptsc_pkg::STATUS_TOO_LONG;
        else if (sp_sel == 8'd0)
            data_next.status = ptsc_pkg::STATUS_TOO_SHORT;
        else
        begin
            data_next.presc_idx       = idx;
            data_next.period_count    = sp_sel - 8'd1;
            data_next.duty_count      = ptsc_pkg::CNT_W'(in_data.dcyc
                                        >> ptsc_pkg::PRESC_SHIFT[idx]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // shorthand for the checks below
    assign res_servo   = valid_reg && data_reg.servo_mode;
    assign res_err     = valid_reg && data_reg.status != ptsc_pkg::STATUS_OK;
    assign res_stall   = valid_reg && !out_ready;
    assign servo_clean = data_reg.presc_idx == 3'd0 && data_reg.period_count == 8'd0
                         && data_reg.status == ptsc_pkg::STATUS_OK;
    assign err_clean   = data_reg.duty_count == 16'd0 && data_reg.period_count == 8'd0
                         && !data_reg.servo_mode;

    `PTSC_ASSERT(a_servo_fields, res_servo |-> servo_clean, "servo result with 8-bit fields set")
    `PTSC_ASSERT(a_err_fields, res_err |-> err_clean, "error result with nonzero fields")
    `PTSC_ASSERT(a_hold, res_stall |=> valid_reg && $stable(data_reg), "stalled result changed")
    `PTSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !valid_reg, "result valid right after reset")

endmodule

@@ hw/rtl/pwm_timing_setting_calculator.sv @@
// Channel   Dir  Signals                         Payload
// s_axis    in   tvalid/tready/tdata[63:0]       one timing request (duty, period in ns)
// m_axis    out  tvalid/tready/tdata[31:0]/tuser timer settings for that request
//
// Four register stages, one request per cycle while m_axis is not stalled; tvalid rises once
// the request has passed through the register of every stage.
// Stages: reciprocal multiply, remainder, correction to cycles, prescaler pick + output reg.
// Each stage has its own valid bit and ready = !valid || downstream ready, so bubbles
// close up and a stalled m_axis only stops the stages that are full.
// rst_n (async, active low) empties the pipeline; no other state exists.
module pwm_timing_setting_calculator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [30:0] duty_time_ns, [61:31] period_time_ns, [63:62] 0
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [2:0] presc_idx, [10:3] period_count,
                                        // [26:11] duty_count, [28:27] status, [31:29] 0
    output logic        m_axis_tuser    // [0] servo_mode
);

    ptsc_pkg::req_t req;
    ptsc_pkg::s1_t  s1_data;
    ptsc_pkg::s2_t  s2_data;
    ptsc_pkg::s3_t  s3_data;
    ptsc_pkg::res_t res;
    logic s1_valid, s1_ready;
    logic s2_valid, s2_ready;
    logic s3_valid, s3_ready;

    // unpack request; bits [63:62] are fill
    assign req.duty_time_ns   = s_axis_tdata[30:0];
    assign req.period_time_ns = s_axis_tdata[61:31];

    ptsc_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    ptsc_resid u_resid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    ptsc_fix u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    ptsc_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // result packing, highest field first
    assign m_axis_tdata = {3'b000, res.status, res.duty_count,
                           res.period_count, res.presc_idx};
    assign m_axis_tuser = res.servo_mode;

endmodule

@@ sim/pwm_timing_setting_calculator_tb.sv @@
// Stream-level check of the PWM timing setting calculator.
// Requests come from a queue that the stimulus process fills. A clocked driver
// feeds them to s_axis, and a clocked monitor checks every m_axis result.
// The monitor compares against settings computed here when each request is accepted.
module pwm_timing_setting_calculator_tb;

    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned DRAIN_CYCLES   = 12;     // pipeline is 4 deep
    localparam int unsigned RAND_PER_PHASE = 281;
    localparam int unsigned MAX_REPORTS    = 10;

    // Timer math as the block is specified: 3 MHz timer clock, 305 ns per servo count
    localparam longint unsigned TIMER_HZ      = 3000000;
    localparam longint unsigned NS_PER_S      = 1000000000;
    localparam longint unsigned SERVO_NS      = 20000000;
    localparam longint unsigned SERVO_NS_STEP = 305;
    localparam longint unsigned SERVO_CAP     = 65535;
    localparam longint unsigned PERIOD_LIMIT  = 255;
    localparam int unsigned     PRESC_CNT     = 8;
    localparam int unsigned     DIV_SHIFT [PRESC_CNT] = '{0, 1, 2, 3, 4, 6, 8, 10};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    ptsc_pkg::req_t pending_reqs [$];   // requests not yet put on s_axis
    ptsc_pkg::res_t want_settings [$];  // settings owed for accepted requests
    ptsc_pkg::req_t next_req;
    ptsc_pkg::res_t got, want;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned checked_cnt   = 0;
    int unsigned servo_cnt     = 0;
    int unsigned short_cnt     = 0;
    int unsigned long_cnt      = 0;

    pwm_timing_setting_calculator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Timer settings for one request.
    // Servo mode is picked by an exact 20 ms period. Everything else takes the
    // first prescaler whose scaled period falls below 255.
    function automatic ptsc_pkg::res_t timer_settings(
        input logic [ptsc_pkg::NS_W-1:0] duty_ns,
        input logic [ptsc_pkg::NS_W-1:0] per_ns
    );
        longint unsigned per_cyc;
        longint unsigned duty_ticks;
        longint unsigned scaled;
        longint unsigned servo_cnt_raw;
        bit              picked;
        ptsc_pkg::res_t  r;
        r        = '0;
        r.status = ptsc_pkg::STATUS_OK;
        picked   = 1'b0;
        if (64'(per_ns) == SERVO_NS)
        begin
            servo_cnt_raw = 64'(duty_ns) / SERVO_NS_STEP;
            r.servo_mode  = 1'b1;
            r.duty_count  = (servo_cnt_raw > SERVO_CAP) ? 16'hFFFF : 16'(servo_cnt_raw);
        end
        else
        begin
            per_cyc    = (64'(per_ns) * TIMER_HZ) / NS_PER_S;
            duty_ticks = (64'(duty_ns) * TIMER_HZ) / NS_PER_S;
            for (int i = 0; i < PRESC_CNT; i++)
            begin
                scaled = per_cyc >> DIV_SHIFT[i];
                if (!picked && scaled < PERIOD_LIMIT)
                begin
                    picked = 1'b1;
                    if (scaled == 0)
                        r.status = ptsc_pkg::STATUS_TOO_SHORT;
                    else
                    begin
                        r.presc_idx    = 3'(i);
                        r.period_count = 8'(scaled - 1);
                        // scaled duty keeps only its low 16 bits
                        r.duty_count   = 16'(duty_ticks >> DIV_SHIFT[i]);
                    end
                end
            end
            if (!picked)
                r.status = ptsc_pkg::STATUS_TOO_LONG;
        end
        return r;
    endfunction

    // Shortest period in ns that converts to the given number of timer cycles.
    function automatic logic [ptsc_pkg::NS_W-1:0] ns_for_cycles(
        input longint unsigned cycles
    );
        return ptsc_pkg::NS_W'((cycles * NS_PER_S + TIMER_HZ - 1) / TIMER_HZ);
    endfunction

    task automatic queue_request(input logic [ptsc_pkg::NS_W-1:0] duty_ns,
                                 input logic [ptsc_pkg::NS_W-1:0] per_ns);
        ptsc_pkg::req_t q;
        q.duty_time_ns   = duty_ns;
        q.period_time_ns = per_ns;
        pending_reqs.push_back(q);
    endtask

    // One random request. Most requests are ordinary 8-bit or servo requests.
    // The rest sit on prescaler edges, are too short, or are unconstrained
    // 31-bit values (mostly too long).
    task automatic queue_random_request();
        int unsigned                kind;
        int unsigned                sh;
        logic [ptsc_pkg::NS_W-1:0]  per;
        logic [ptsc_pkg::NS_W-1:0]  duty;
        kind = $urandom_range(99);
        sh   = DIV_SHIFT[$urandom_range(PRESC_CNT - 1)];
        duty = ptsc_pkg::NS_W'($urandom());
        if (kind < 15)
        begin
            per = ptsc_pkg::NS_W'(SERVO_NS);
            if ($urandom_range(1) == 0)
                duty = ptsc_pkg::NS_W'($urandom_range(20500000));
        end
        else if (kind < 55)
        begin
            per = ptsc_pkg::NS_W'($urandom_range(ns_for_cycles(PERIOD_LIMIT << sh), 334));
            if ($urandom_range(3) != 0)
                duty = ptsc_pkg::NS_W'($urandom_range(per));
        end
        else if (kind < 68)
        begin
            per = ns_for_cycles(PERIOD_LIMIT << sh)
                  + ptsc_pkg::NS_W'($urandom_range(8)) - ptsc_pkg::NS_W'(4);
            if ($urandom_range(1) == 0)
                duty = ptsc_pkg::NS_W'($urandom_range(per));
        end
        else if (kind < 78)
            per = ptsc_pkg::NS_W'($urandom_range(333));
        else
            per = ptsc_pkg::NS_W'($urandom());
        queue_request(duty, per);
    endtask

    // Driver: a new request is offered only when s_axis is free or moving.
    // Settings are computed at the edge where the request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                want_settings.push_back(timer_settings(s_axis_tdata[30:0],
                                                       s_axis_tdata[61:31]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req      = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, next_req.period_time_ns, next_req.duty_time_ns};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result against the oldest owed settings.
    // Stalls are drawn fresh every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.servo_mode   = m_axis_tuser;
                got.presc_idx    = m_axis_tdata[2:0];
                got.period_count = m_axis_tdata[10:3];
                got.duty_count   = m_axis_tdata[26:11];
                got.status       = ptsc_pkg::status_t'(m_axis_tdata[28:27]);
                if (want_settings.size() == 0)
                begin
                    mismatch_cnt = mismatch_cnt + 1;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected result: servo=%0d presc=%0d per=%0d duty=%0d st=%0d",
                                 got.servo_mode, got.presc_idx, got.period_count,
                                 got.duty_count, got.status);
                end
                else
                begin
                    want        = want_settings.pop_front();
                    checked_cnt = checked_cnt + 1;
                    if (want.servo_mode)
                        servo_cnt = servo_cnt + 1;
                    if (want.status == ptsc_pkg::STATUS_TOO_SHORT)
                        short_cnt = short_cnt + 1;
                    if (want.status == ptsc_pkg::STATUS_TOO_LONG)
                        long_cnt = long_cnt + 1;
                    if (got.servo_mode   !== want.servo_mode   ||
                        got.presc_idx    !== want.presc_idx    ||
                        got.period_count !== want.period_count ||
                        got.duty_count   !== want.duty_count   ||
                        got.status       !== want.status)
                    begin
                        mismatch_cnt = mismatch_cnt + 1;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"result %0d mismatch: exp servo=%0d presc=%0d per=%0d ",
                                      "duty=%0d st=%0d, got servo=%0d presc=%0d per=%0d ",
                                      "duty=%0d st=%0d"},
                                     checked_cnt, want.servo_mode, want.presc_idx,
                                     want.period_count, want.duty_count, want.status,
                                     got.servo_mode, got.presc_idx, got.period_count,
                                     got.duty_count, got.status);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        wait (cycle_cnt == TIMEOUT_CYCLES);
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_cnt, want_settings.size());
        $display("pwm_timing_setting_calculator_tb: done, errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: both extremes of each field, the too-short limit,
        // servo saturation, 16-bit duty wrap, and both sides of every prescaler step.
        queue_request(31'd0, 31'd0);
        queue_request(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_request(31'd1000, 31'd333);                 // zero timer cycles
        queue_request(31'd100, 31'd334);                  // one timer cycle
        queue_request(31'd0, 31'(SERVO_NS));
        queue_request(31'd19988479, 31'(SERVO_NS));       // just under saturation
        queue_request(31'd19988480, 31'(SERVO_NS));       // count 65536 clamps
        queue_request(31'h7FFF_FFFF, 31'(SERVO_NS));
        queue_request(31'd1500000, 31'(SERVO_NS - 1));    // near servo, stays 8-bit
        queue_request(31'h7FFF_FFFF, 31'd1000);           // duty wraps at 16 bits
        for (int i = 0; i < PRESC_CNT; i++)
        begin
            queue_request(31'd5000, ns_for_cycles(PERIOD_LIMIT << DIV_SHIFT[i]) - 31'd1);
            queue_request(31'd5000, ns_for_cycles(PERIOD_LIMIT << DIV_SHIFT[i]));
        end

        // Pressure phases: free flow, sender gaps, receiver stalls, then both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 28 : 0;
            stall_pct     = (ph == 2) ? 59 : (ph == 3) ? 28 : 0;
            for (int n = 0; n < RAND_PER_PHASE; n++)
                queue_random_request();
            while (pending_reqs.size() != 0 || s_axis_tvalid || want_settings.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d requests (%0d servo, %0d too short, %0d too long)",
                 checked_cnt, servo_cnt, short_cnt, long_cnt);
        $display("four pressure phases; %0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0 && want_settings.size() == 0)
            $display("pwm_timing_setting_calculator_tb: done, clean");
        else
            $display("pwm_timing_setting_calculator_tb: done, errors");
        $finish;
    end

endmodule
